[rtl/ile_pkg.sv]
// Package for the indexed list engine: field widths, codes and control types.
`default_nettype none
package ile_pkg;

  localparam int unsigned OPC_W    = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned ECOUNT_W = 5;

  typedef enum logic [OPC_W-1:0] {
    OP_APPEND = 2'd0,
    OP_GET    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic execute;
  } ile_cmd_t;

endpackage
`default_nettype wire

[rtl/ile_ctrl.sv]
// Controller state machine of the indexed list engine.
`default_nettype none
module ile_ctrl
  import ile_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output ile_cmd_t      cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    in_ready    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        // The result register must be free, or be emptied in this cycle.
        if (!out_valid_r || out_ready) begin
          cmd.execute = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.execute) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTH
  a_exec_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute |-> (!out_valid_r || out_ready))
    else $error("result overwritten while still waiting");

  a_valid_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.execute))
    else $error("result raised without an execute");

  a_exec_after_capture: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute |-> $past(cmd.capture) || (state_r == S_EXEC && $past(state_r == S_EXEC)))
    else $error("execute without a captured request");
`endif

endmodule
`default_nettype wire

[rtl/ile_dpath.sv]
// Datapath of the indexed list engine: request, entry row, count and result registers.
`default_nettype none
module ile_dpath
  import ile_pkg::*;
#(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire ile_cmd_t                   cmd,
  input  wire logic [OPC_W-1:0]           in_opcode,
  input  wire logic signed [VALUE_W-1:0]  in_value,
  input  wire logic [IDX_W-1:0]           in_index,
  output logic signed [VALUE_W-1:0]       out_read_value,
  output logic [STATUS_W-1:0]             out_status,
  output logic [ECOUNT_W-1:0]             out_entry_count
);

  localparam int unsigned ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  // Captured request.
  opcode_t                    op_r;
  logic signed [VALUE_W-1:0]  value_r;
  logic [IDX_W-1:0]           index_r;

  logic signed [DATA_WIDTH-1:0] entries_r [CAPACITY];
  logic [CNT_W-1:0]             count_r, count_nxt;

  logic signed [VALUE_W-1:0]  read_value_r, read_value_nxt;
  status_t                    status_r, status_nxt;
  logic [ECOUNT_W-1:0]        entry_count_r;

  logic [CMP_W-1:0]           idx_cmp;
  logic                       idx_ok;
  logic                       full;
  logic signed [DATA_WIDTH-1:0] rd_word;
  logic signed [63:0]         rd_ext;
  logic signed [63:0]         val_ext;
  logic [CNT_W+ECOUNT_W-1:0]  cnt_ext;
  logic                       do_append;
  logic                       do_remove;

  assign idx_cmp   = CMP_W'(index_r);
  assign idx_ok    = (idx_cmp < CMP_W'(count_r)) && (idx_cmp < CMP_W'(CAPACITY));
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign rd_word   = entries_r[idx_cmp[ADDR_W-1:0]];
  assign rd_ext    = 64'(rd_word);
  assign val_ext   = 64'(value_r);
  assign do_append = cmd.execute && (op_r == OP_APPEND) && !full;
  assign do_remove = cmd.execute && (op_r == OP_REMOVE) && idx_ok;

  always_comb begin
    count_nxt      = count_r;
    status_nxt     = ST_OK;
    read_value_nxt = '0;
    unique case (op_r)
      OP_APPEND: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_GET: begin
        if (!idx_ok) begin
          status_nxt = ST_RANGE;
        end else begin
          read_value_nxt = rd_ext[VALUE_W-1:0];
        end
      end
      OP_REMOVE: begin
        if (!idx_ok) begin
          status_nxt = ST_RANGE;
        end else begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      OP_CLEAR: count_nxt = '0;
      default:  count_nxt = count_r;
    endcase
  end

  assign cnt_ext = {{ECOUNT_W{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.execute) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= opcode_t'(in_opcode);
      value_r <= in_value;
      index_r <= in_index;
    end
    if (cmd.execute) begin
      read_value_r  <= read_value_nxt;
      status_r      <= status_nxt;
      entry_count_r <= cnt_ext[ECOUNT_W-1:0];
    end
  end

  // Entry row: append writes at the tail, remove shifts every later entry down one place.
  always_ff @(posedge clk) begin
    if (do_append) begin
      entries_r[count_r[ADDR_W-1:0]] <= val_ext[DATA_WIDTH-1:0];
    end
    for (int i = 0; i < CAPACITY - 1; i++) begin
      if (do_remove && (CMP_W'(i) >= idx_cmp)) begin
        entries_r[i] <= entries_r[i+1];
      end
    end
  end

  assign out_read_value  = read_value_r;
  assign out_status      = status_r;
  assign out_entry_count = entry_count_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_full_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.execute && op_r == OP_APPEND && full) |=> count_r == $past(count_r))
    else $error("append to full list changed the count");

  a_error_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.execute && status_nxt != ST_OK) |=> read_value_r == '0)
    else $error("error result carries a non-zero value");
`endif

endmodule
`default_nettype wire

[rtl/indexed_list_engine.sv]
// Top level of the indexed list engine: controller and datapath joined by commands.
// A request is captured in the idle state and executed in the execute state, which
// loads the result registers; in_ready is high only in the idle state, so no new
// request is taken meanwhile, and a stalled consumer holds back the execute step.
// Reset: rst_n is synchronous and active low; it empties the list and drops out_valid.
// Entry contents are not cleared; entries past the count are never read.
`default_nettype none
module indexed_list_engine
  import ile_pkg::*;
#(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [OPC_W-1:0]           in_opcode,
  input  wire logic signed [VALUE_W-1:0]  in_value,
  input  wire logic [IDX_W-1:0]           in_index,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed [VALUE_W-1:0]       out_read_value,
  output logic [STATUS_W-1:0]             out_status,
  output logic [ECOUNT_W-1:0]             out_entry_count
);

  // The controller sequences each request through capture and execute; the
  // datapath holds the list as a register row, so a removal shifts every later
  // entry down one place at once, on execute.
  ile_cmd_t cmd;

  ile_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // The result registers live in the datapath; they are loaded only on execute,
  // which the controller holds back while an earlier result still waits.
  ile_dpath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_opcode       (in_opcode),
    .in_value        (in_value),
    .in_index        (in_index),
    .out_read_value  (out_read_value),
    .out_status      (out_status),
    .out_entry_count (out_entry_count)
  );

endmodule
`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking testbench for the indexed list engine: scoreboard class, stimulus and top.
`timescale 1ns / 1ps

import ile_pkg::*;

typedef struct packed {
  logic signed [VALUE_W-1:0] read_value;
  status_t                   status;
  logic [ECOUNT_W-1:0]       entry_count;
} list_result_t;

class list_scoreboard;
  localparam int unsigned DEPTH = 16;

  logic signed [VALUE_W-1:0] entries [DEPTH];
  int unsigned               list_count;
  list_result_t              awaited_results [$];
  int unsigned               errors;

  function new();
    list_count = 0;
    errors     = 0;
  endfunction

  function int unsigned pending();
    return awaited_results.size();
  endfunction

  // Applies one accepted request to the list copy and queues its answer.
  function void note_request(opcode_t op, logic signed [VALUE_W-1:0] word,
                             logic [IDX_W-1:0] pos);
    list_result_t ans;
    ans.read_value = '0;
    ans.status     = ST_OK;
    case (op)
      OP_APPEND: begin
        if (list_count >= DEPTH) begin
          ans.status = ST_FULL;
        end else begin
          entries[list_count] = word;
          list_count++;
        end
      end
      OP_GET: begin
        if (pos >= list_count) begin
          ans.status = ST_RANGE;
        end else begin
          ans.read_value = entries[pos];
        end
      end
      OP_REMOVE: begin
        if (pos >= list_count) begin
          ans.status = ST_RANGE;
        end else begin
          for (int unsigned i = pos; i + 1 < list_count; i++) begin
            entries[i] = entries[i + 1];
          end
          list_count--;
        end
      end
      default: begin
        list_count = 0;
      end
    endcase
    ans.entry_count = list_count[ECOUNT_W-1:0];
    awaited_results.push_back(ans);
  endfunction

  function void check_result(list_result_t got);
    list_result_t want;
    if (awaited_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, got value %0d status %0d count %0d",
               $time, got.read_value, got.status, got.entry_count);
      errors++;
      return;
    end
    want = awaited_results.pop_front();
    if (got.read_value !== want.read_value) begin
      $display("%0t: read_value expected %0d, got %0d", $time, want.read_value,
               got.read_value);
      errors++;
    end
    if (got.status !== want.status) begin
      $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
      errors++;
    end
    if (got.entry_count !== want.entry_count) begin
      $display("%0t: entry_count expected %0d, got %0d", $time, want.entry_count,
               got.entry_count);
      errors++;
    end
  endfunction
endclass

module testbench;

  // The list is built at its default size, so the scoreboard can hold a fixed copy.
  localparam int unsigned LIST_DEPTH   = 16;
  localparam int unsigned RANDOM_ITEMS = 1600;
  localparam int unsigned CALM_TAIL    = 200;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic [OPC_W-1:0]          in_opcode;
  logic signed [VALUE_W-1:0] in_value;
  logic [IDX_W-1:0]          in_index;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [VALUE_W-1:0] out_read_value;
  logic [STATUS_W-1:0]       out_status;
  logic [ECOUNT_W-1:0]       out_entry_count;

  list_scoreboard sb = new();

  // Shared between the sender and the receiver: whether random idling is on, and a
  // request from the sender for one long hold-off on the result side.
  bit          idling;
  bit          hold_req;
  bit          growing;
  int unsigned cycles;

  indexed_list_engine #(
    .CAPACITY   (LIST_DEPTH),
    .DATA_WIDTH (VALUE_W)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_value        (in_value),
    .in_index        (in_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_read_value  (out_read_value),
    .out_status      (out_status),
    .out_entry_count (out_entry_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("indexed_list_engine regression: fail");
      $finish;
    end
  end

  // Both handshakes are sampled at the clock edge. Inputs change only through
  // nonblocking assignments, so what is seen here is the value before the edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.note_request(opcode_t'(in_opcode), in_value, in_index);
      end
      if (out_valid && out_ready) begin
        sb.check_result('{out_read_value, status_t'(out_status), out_entry_count});
      end
    end
  end

  // Result side. It stalls in random bursts while idling is on, and once holds off
  // for a long stretch so that a result waits and the engine refuses further requests.
  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  // Offers one request and returns at the edge where it is taken. The valid line is
  // left high, so a back-to-back request needs only a new payload.
  task automatic offer_request(opcode_t op, logic [VALUE_W-1:0] word,
                               logic [IDX_W-1:0] pos);
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_value  <= word;
    in_index  <= pos;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic idle_sender(int unsigned gap);
    in_valid <= 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  // Stops offering until every outstanding request has been answered.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Extremes turn up often, so sign and all-ones patterns are stored and read back.
  function automatic logic [VALUE_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // Mostly well-formed traffic: the list is grown towards full, then shrunk towards
  // empty, with positions chosen mainly inside the list and otherwise over the whole
  // depth, which also exercises positions past the end. A tenth of the opcodes are plain noise.
  task automatic offer_random_request();
    opcode_t          op;
    logic [IDX_W-1:0] pos;
    int unsigned      roll;
    int unsigned      filled;
    filled = sb.list_count;
    if (growing && filled == LIST_DEPTH && $urandom_range(0, 3) == 0) begin
      growing = 1'b0;
    end else if (!growing && filled == 0) begin
      growing = 1'b1;
    end
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      op = opcode_t'($urandom_range(0, 3));
    end else if (growing) begin
      if (roll < 60) op = OP_APPEND;
      else if (roll < 83) op = OP_GET;
      else if (roll < 98) op = OP_REMOVE;
      else op = OP_CLEAR;
    end else begin
      if (roll < 25) op = OP_APPEND;
      else if (roll < 50) op = OP_GET;
      else if (roll < 97) op = OP_REMOVE;
      else op = OP_CLEAR;
    end
    if (filled > 0 && $urandom_range(0, 9) < 8) begin
      pos = IDX_W'($urandom_range(0, filled - 1));
    end else begin
      pos = IDX_W'($urandom_range(0, LIST_DEPTH - 1));
    end
    offer_request(op, pick_word(), pos);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_opcode = '0;
    in_value  = '0;
    in_index  = '0;
    idling    = 1'b0;
    hold_req  = 1'b0;
    growing   = 1'b1;
    cycles    = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: an empty list refuses reads and removals, the signed extremes
    // survive a round trip, a removal from the middle closes the gap, the list is
    // filled until an append is refused, and a clear empties it again.
    offer_request(OP_CLEAR, '0, '0);
    offer_request(OP_GET, '0, 4'd0);
    offer_request(OP_REMOVE, '0, 4'd15);
    offer_request(OP_APPEND, 32'h8000_0000, '0);
    offer_request(OP_APPEND, 32'h7fff_ffff, '0);
    offer_request(OP_APPEND, 32'h0000_0000, '0);
    offer_request(OP_APPEND, 32'hffff_ffff, '0);
    offer_request(OP_GET, '0, 4'd0);
    offer_request(OP_GET, '0, 4'd1);
    offer_request(OP_GET, '0, 4'd3);
    offer_request(OP_GET, '0, 4'd4);
    offer_request(OP_REMOVE, '0, 4'd1);
    offer_request(OP_GET, '0, 4'd1);
    offer_request(OP_REMOVE, '0, 4'd2);
    offer_request(OP_REMOVE, '0, 4'd0);
    for (int k = 0; k < LIST_DEPTH - 1; k++) begin
      offer_request(OP_APPEND, (k % 2) ? 32'haaaa_aaaa : 32'h5555_5555, '0);
    end
    offer_request(OP_APPEND, 32'h1234_5678, '0);
    offer_request(OP_GET, '0, 4'd15);
    offer_request(OP_REMOVE, '0, 4'd15);
    offer_request(OP_CLEAR, '0, 4'd15);
    offer_request(OP_GET, '0, 4'd0);

    // Random part. Idling is chosen afresh every hundred requests, with some calm
    // stretches, and is switched off entirely for the closing stretch.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        idling = (n < RANDOM_ITEMS - CALM_TAIL) && ($urandom_range(0, 3) != 0);
      end
      if (n == 300) begin
        hold_req = 1'b1;
      end
      if (n == 600 || n == 1200) begin
        drain_results();
      end
      if (idling && $urandom_range(0, 4) == 0) begin
        idle_sender($urandom_range(1, 15));
      end
      offer_random_request();
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    // Keep the clock running so that a stray extra result would still be caught.
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("indexed_list_engine regression: pass");
    end else begin
      $display("indexed_list_engine regression: fail");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/ile_pkg.sv
rtl/ile_ctrl.sv
rtl/ile_dpath.sv
rtl/indexed_list_engine.sv
tb/sv/testbench.sv
